@@ rtl/kway_merge_min_heap_unit_macros.svh @@
// ============================================================================
// kway_merge_min_heap_unit_macros.svh
// Assertion shorthands for the k-way merge heap unit.
// ============================================================================
`ifndef KWAY_MERGE_MIN_HEAP_UNIT_MACROS_SVH
`define KWAY_MERGE_MIN_HEAP_UNIT_MACROS_SVH

// same-cycle implication
`define KWMH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KWMH_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kwmh_pkg.sv @@
// ============================================================================
// kwmh_pkg
// Word types, command codes and controller states of the merge heap unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kwmh_pkg;

    localparam int LIST_W = 4;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [LIST_W-1:0]        list_id;
        logic signed [DATA_W-1:0] value;
        logic                     exhausted;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [LIST_W-1:0]        popped_list;
        logic                     popped_valid;
        logic [LIST_W-1:0]        next_list;
        logic                     next_valid;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_CHK,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_SIFT,
        ST_FIN_RD,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

@@ rtl/kway_merge_min_heap_unit.sv @@
// K-way merge unit built on a binary min-heap held in a two-read, one-write
// synchronous RAM. Load words write one list head each; loading the last slot
// (num_lists-1) heapifies bottom-up and returns the list owning the root. Pop
// words return the root and replace it with the supplied next element of that
// list, then sift it down; a pop on an exhausted root pops nothing and leaves
// the heap as it is. A load of any other slot gives no result. A build sifts
// down each of the num_lists/2 interior slots. An element sinks at most 4
// levels for 16 lists; per level the sift does one RAM read of both children
// and one write-back. Results sit in an output register, so the next word is
// taken while one waits.
// ============================================================================
// kway_merge_min_heap_unit
// Min-heap k-way merge engine with a RAM-based sift-down controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "kway_merge_min_heap_unit_macros.svh"

module kway_merge_min_heap_unit #(
    parameter int MAX_LISTS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire kwmh_pkg::in_word_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output kwmh_pkg::out_word_t               m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [kwmh_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_LISTS);
    localparam int SZ_RAW = $clog2(MAX_LISTS + 1);
    localparam int SZ_W   = (SZ_RAW > kwmh_pkg::CFG_W) ? SZ_RAW : kwmh_pkg::CFG_W;
    localparam int CMP_W  = (IDX_W + 2 > SZ_W) ? IDX_W + 2 : SZ_W;

    typedef struct packed {
        logic                        exh;
        logic [kwmh_pkg::LIST_W-1:0] lst;
        logic [VALUE_WIDTH-1:0]      val;
    } entry_t;

    function automatic logic less(input entry_t a, input entry_t b);
        less = !a.exh && (b.exh || ($signed(a.val) < $signed(b.val)));
    endfunction

    // heap RAM
    entry_t             mem [MAX_LISTS];
    entry_t             rd_a_reg;
    entry_t             rd_b_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    entry_t             mem_wd;
    logic [IDX_W-1:0]   mem_ra;
    logic [IDX_W-1:0]   mem_rb;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_a_reg <= mem[mem_ra];
        rd_b_reg <= mem[mem_rb];
    end

    kwmh_pkg::state_t            state_reg, state_next;
    logic [IDX_W-1:0]            k_reg, k_next;
    logic [IDX_W-1:0]            cur_reg, cur_next;
    entry_t                      elem_reg, elem_next;
    logic                        bld_reg, bld_next;
    logic [VALUE_WIDTH-1:0]      pv_reg, pv_next;
    logic [kwmh_pkg::LIST_W-1:0] pl_reg, pl_next;
    logic                        pvalid_reg, pvalid_next;
    logic [kwmh_pkg::CFG_W-1:0]  num_lists_reg;
    logic                        m_valid_reg, m_valid_next;
    kwmh_pkg::out_word_t         m_data_reg, m_data_next;

    logic [SZ_W-1:0]      size_w;
    logic [SZ_W-1:0]      size_half;
    logic [CMP_W-1:0]     size_c;
    logic [CMP_W-1:0]     left_c;
    logic [CMP_W-1:0]     right_c;
    logic                 left_ok;
    logic                 right_ok;
    logic                 take_l;
    logic                 take_r;
    logic [IDX_W-1:0]     best_idx;
    logic [IDX_W-1:0]     ch_node;
    logic [IDX_W:0]       ch_base;
    logic [IDX_W:0]       ch_rgt;
    logic [63:0]          in_ext;
    logic [63:0]          out_ext;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                 out_free;
    logic                 id_ok;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        if (num_lists_reg == '0) begin
            size_w = SZ_W'(1);
        end else if (SZ_W'(num_lists_reg) > SZ_W'(MAX_LISTS)) begin
            size_w = SZ_W'(MAX_LISTS);
        end else begin
            size_w = SZ_W'(num_lists_reg);
        end
    end

    assign size_half = size_w >> 1;
    assign size_c    = CMP_W'(size_w);
    assign left_c    = CMP_W'({cur_reg, 1'b1});
    assign right_c   = left_c + CMP_W'(1);
    assign left_ok   = left_c < size_c;
    assign right_ok  = right_c < size_c;

    always_comb begin
        if (left_ok && less(rd_a_reg, elem_reg)) begin
            take_r = right_ok && less(rd_b_reg, rd_a_reg);
            take_l = !take_r;
        end else begin
            take_r = right_ok && less(rd_b_reg, elem_reg);
            take_l = 1'b0;
        end
    end

    assign best_idx = take_r ? right_c[IDX_W-1:0] : left_c[IDX_W-1:0];

    always_comb begin
        case (state_reg)
            kwmh_pkg::ST_SIFT:   ch_node = best_idx;
            kwmh_pkg::ST_BLD_LD: ch_node = k_reg;
            default:             ch_node = '0;
        endcase
    end

    assign ch_base = {ch_node, 1'b1};
    assign ch_rgt  = ch_base + (IDX_W + 1)'(1);

    assign in_ext  = {32'h0, s_data.value};
    assign in_val  = in_ext[VALUE_WIDTH-1:0];
    assign out_ext = 64'(pv_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign id_ok   = SZ_W'(s_data.list_id) < SZ_W'(MAX_LISTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kwmh_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            num_lists_reg <= kwmh_pkg::CFG_W'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                num_lists_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        elem_reg   <= elem_next;
        bld_reg    <= bld_next;
        pv_reg     <= pv_next;
        pl_reg     <= pl_next;
        pvalid_reg <= pvalid_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        elem_next    = elem_reg;
        bld_next     = bld_reg;
        pv_next      = pv_reg;
        pl_next      = pl_reg;
        pvalid_next  = pvalid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_wa       = cur_reg;
        mem_wd       = elem_reg;
        mem_ra       = '0;
        mem_rb       = '0;
        s_ready      = 1'b0;

        case (state_reg)
            kwmh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.cmd == kwmh_pkg::CMD_POP) begin
                        elem_next.val = in_val;
                        elem_next.exh = s_data.exhausted;
                        state_next    = kwmh_pkg::ST_POP_CHK;
                    end else if (id_ok) begin
                        mem_we     = 1'b1;
                        mem_wa     = IDX_W'(s_data.list_id);
                        mem_wd.exh = s_data.exhausted;
                        mem_wd.lst = s_data.list_id;
                        mem_wd.val = in_val;
                        if (SZ_W'(s_data.list_id) == size_w - SZ_W'(1)) begin
                            pv_next     = '0;
                            pl_next     = '0;
                            pvalid_next = 1'b0;
                            bld_next    = 1'b1;
                            if (size_half != '0) begin
                                k_next     = IDX_W'(size_half - SZ_W'(1));
                                state_next = kwmh_pkg::ST_BLD_RD;
                            end else begin
                                state_next = kwmh_pkg::ST_FIN_RD;
                            end
                        end
                    end
                end
            end
            kwmh_pkg::ST_POP_CHK: begin
                if (rd_a_reg.exh) begin
                    pv_next     = '0;
                    pl_next     = '0;
                    pvalid_next = 1'b0;
                    state_next  = kwmh_pkg::ST_FIN;
                end else begin
                    pv_next       = rd_a_reg.val;
                    pl_next       = rd_a_reg.lst;
                    pvalid_next   = 1'b1;
                    elem_next.lst = rd_a_reg.lst;
                    cur_next      = '0;
                    bld_next      = 1'b0;
                    mem_ra        = ch_base[IDX_W-1:0];
                    mem_rb        = ch_rgt[IDX_W-1:0];
                    state_next    = kwmh_pkg::ST_SIFT;
                end
            end
            kwmh_pkg::ST_BLD_RD: begin
                mem_ra     = k_reg;
                state_next = kwmh_pkg::ST_BLD_LD;
            end
            kwmh_pkg::ST_BLD_LD: begin
                elem_next  = rd_a_reg;
                cur_next   = k_reg;
                mem_ra     = ch_base[IDX_W-1:0];
                mem_rb     = ch_rgt[IDX_W-1:0];
                state_next = kwmh_pkg::ST_SIFT;
            end
            kwmh_pkg::ST_SIFT: begin
                mem_we = 1'b1;
                mem_wa = cur_reg;
                if (take_l || take_r) begin
                    mem_wd   = take_r ? rd_b_reg : rd_a_reg;
                    cur_next = best_idx;
                    mem_ra   = ch_base[IDX_W-1:0];
                    mem_rb   = ch_rgt[IDX_W-1:0];
                end else begin
                    mem_wd = elem_reg;
                    if (bld_reg && (k_reg != '0)) begin
                        k_next     = k_reg - IDX_W'(1);
                        state_next = kwmh_pkg::ST_BLD_RD;
                    end else begin
                        state_next = kwmh_pkg::ST_FIN_RD;
                    end
                end
            end
            kwmh_pkg::ST_FIN_RD: begin
                state_next = kwmh_pkg::ST_FIN;
            end
            kwmh_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.popped_value = out_ext[kwmh_pkg::DATA_W-1:0];
                    m_data_next.popped_list  = pl_reg;
                    m_data_next.popped_valid = pvalid_reg;
                    m_data_next.next_list    = rd_a_reg.lst;
                    m_data_next.next_valid   = !rd_a_reg.exh;
                    state_next               = kwmh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kwmh_pkg::ST_IDLE;
            end
        endcase
    end

    `KWMH_ASSERT_IMP(a_sift_in_heap, aclk, aresetn, state_reg == kwmh_pkg::ST_SIFT, SZ_W'(cur_reg) < size_w, "sift node outside heap")
    `KWMH_ASSERT_IMP(a_write_in_ram, aclk, aresetn, mem_we, SZ_W'(mem_wa) < SZ_W'(MAX_LISTS), "heap write out of range")
    `KWMH_ASSERT_NXT(a_fin_delivers, aclk, aresetn, (state_reg == kwmh_pkg::ST_FIN) && out_free, m_valid_reg && (state_reg == kwmh_pkg::ST_IDLE), "result not loaded")

endmodule

`default_nettype wire

@@ tb/tb_kway_merge_min_heap_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_kway_merge_min_heap_unit
// Self-checking bench for the k-way merge min-heap unit. Sorted lists are
// loaded and built into the heap, then popped with well-formed next elements
// until exhausted, mixed with stray loads and pops. A local heap model
// predicts each result word in order. Sender gaps, receiver stalls and one
// long receiver hold-off vary by phase, across several num_lists settings.
// ============================================================================

module tb_kway_merge_min_heap_unit;

    localparam int HEAP_SLOTS     = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [HEAP_SLOTS-1:0][kwmh_pkg::DATA_W-1:0] val;
        logic [HEAP_SLOTS-1:0][kwmh_pkg::LIST_W-1:0] lst;
        logic [HEAP_SLOTS-1:0]                       exh;
        logic [kwmh_pkg::CFG_W-1:0]                  nlists;
    } heap_model_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    kwmh_pkg::in_word_t          s_data    = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    kwmh_pkg::out_word_t         m_data;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [kwmh_pkg::CFG_W-1:0]  cfg_wdata = '0;

    kwmh_pkg::in_word_t  word_backlog[$];
    kwmh_pkg::out_word_t expected_merge_out[$];
    heap_model_t       plan_heap;
    heap_model_t       dut_heap;
    logic [HEAP_SLOTS-1:0] plan_written;
    int                err_count   = 0;
    int                gap_pct     = 0;
    int                stall_pct   = 0;
    bit                hold_req    = 1'b0;
    bit                hold_done   = 1'b0;
    int                hold_left   = 0;
    int                idle_cycles = 0;

    kway_merge_min_heap_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // heap model
    // ------------------------------------------------------------------------
    function automatic int eff_size(logic [kwmh_pkg::CFG_W-1:0] n);
        if (n == 0) return 1;
        if (n > HEAP_SLOTS) return HEAP_SLOTS;
        return int'(n);
    endfunction

    // exhausted entries rank above every value; ties keep the parent
    function automatic bit ranks_below(heap_model_t h, int a, int b);
        if (h.exh[a]) return 1'b0;
        if (h.exh[b]) return 1'b1;
        return $signed(h.val[a]) < $signed(h.val[b]);
    endfunction

    function automatic heap_model_t sift_heap(heap_model_t h, int start, int size);
        int cur;
        int best;
        int kid;
        logic [kwmh_pkg::DATA_W-1:0] tv;
        logic [kwmh_pkg::LIST_W-1:0] tl;
        logic                        te;
        cur = start;
        while (1) begin
            best = cur;
            for (kid = 2 * cur + 1; kid <= 2 * cur + 2; kid++) begin
                if (kid < size && ranks_below(h, kid, best)) best = kid;
            end
            if (best == cur) break;
            tv = h.val[cur]; tl = h.lst[cur]; te = h.exh[cur];
            h.val[cur] = h.val[best]; h.lst[cur] = h.lst[best]; h.exh[cur] = h.exh[best];
            h.val[best] = tv; h.lst[best] = tl; h.exh[best] = te;
            cur = best;
        end
        return h;
    endfunction

    function automatic bit heap_apply(inout heap_model_t h,
                                      input kwmh_pkg::in_word_t w,
                                      output kwmh_pkg::out_word_t r);
        int size;
        int k;
        size = eff_size(h.nlists);
        r = '0;
        if (w.cmd == kwmh_pkg::CMD_LOAD) begin
            h.val[w.list_id] = w.value;
            h.lst[w.list_id] = w.list_id;
            h.exh[w.list_id] = w.exhausted;
            if (int'(w.list_id) != size - 1) return 1'b0;
            for (k = size / 2 - 1; k >= 0; k--) h = sift_heap(h, k, size);
            r.next_list  = h.lst[0];
            r.next_valid = !h.exh[0];
            return 1'b1;
        end
        if (h.exh[0]) begin
            r.next_list = h.lst[0];
            return 1'b1;
        end
        r.popped_value = h.val[0];
        r.popped_list  = h.lst[0];
        r.popped_valid = 1'b1;
        h.val[0] = w.value;
        h.exh[0] = w.exhausted;
        h = sift_heap(h, 0, size);
        r.next_list  = h.lst[0];
        r.next_valid = !h.exh[0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------------
    task automatic push_word(input logic c, input logic [kwmh_pkg::LIST_W-1:0] id,
                             input logic [kwmh_pkg::DATA_W-1:0] v, input logic ex);
        kwmh_pkg::in_word_t  w;
        kwmh_pkg::out_word_t r;
        w.cmd = c;
        w.list_id = id;
        w.value = v;
        w.exhausted = ex;
        void'(heap_apply(plan_heap, w, r));
        if (c == kwmh_pkg::CMD_LOAD) plan_written[id] = 1'b1;
        word_backlog.push_back(w);
    endtask

    // true when the word never touches a slot that was not yet written
    function automatic bit slots_ready(logic c, logic [kwmh_pkg::LIST_W-1:0] id);
        int size;
        int k;
        logic [HEAP_SLOTS-1:0] m;
        size = eff_size(plan_heap.nlists);
        if (c == kwmh_pkg::CMD_LOAD && int'(id) != size - 1) return 1'b1;
        m = plan_written;
        if (c == kwmh_pkg::CMD_LOAD) m[id] = 1'b1;
        for (k = 0; k < size; k++) if (!m[k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [kwmh_pkg::DATA_W-1:0] head_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(200);
            2: return -$urandom_range(200);
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(50) - 25;
        endcase
    endfunction

    task automatic gen_build(output int made);
        int size;
        int order[HEAP_SLOTS];
        int k;
        int j;
        int t;
        size = eff_size(plan_heap.nlists);
        for (k = 0; k < size - 1; k++) order[k] = k;
        for (k = size - 2; k > 0; k--) begin
            j = $urandom_range(k);
            t = order[k]; order[k] = order[j]; order[j] = t;
        end
        for (k = 0; k < size - 1; k++)
            push_word(kwmh_pkg::CMD_LOAD, kwmh_pkg::LIST_W'(order[k]), head_value(),
                      $urandom_range(11) == 0);
        push_word(kwmh_pkg::CMD_LOAD, kwmh_pkg::LIST_W'(size - 1), head_value(),
                  $urandom_range(11) == 0);
        made = size;
    endtask

    // next element of the root's list: never below the popped head
    task automatic gen_pop();
        logic signed [kwmh_pkg::DATA_W-1:0] root;
        logic signed [kwmh_pkg::DATA_W-1:0] nxt;
        root = plan_heap.val[0];
        if (plan_heap.exh[0]) begin
            push_word(kwmh_pkg::CMD_POP, kwmh_pkg::LIST_W'($urandom_range(15)), $urandom,
                      1'($urandom_range(1)));
        end else begin
            if (root > 32'sh7fffffff - 300) nxt = 32'sh7fffffff;
            else nxt = root + $urandom_range(300);
            push_word(kwmh_pkg::CMD_POP, kwmh_pkg::LIST_W'($urandom_range(15)), nxt,
                      $urandom_range(9) == 0);
        end
    endtask

    task automatic gen_noise();
        logic                        c;
        logic [kwmh_pkg::LIST_W-1:0] id;
        int                          size;
        size = eff_size(plan_heap.nlists);
        c  = 1'($urandom_range(1));
        id = kwmh_pkg::LIST_W'($urandom_range(15));
        if (!slots_ready(c, id)) begin
            c = kwmh_pkg::CMD_LOAD;
            if (int'(id) == size - 1) id = id + 1'b1;
        end
        push_word(c, id, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic gen_phase(input int n_items);
        int made;
        int n;
        int r;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(99);
            if (!slots_ready(kwmh_pkg::CMD_POP, 0)) begin
                gen_build(n);
                made += n;
            end else if (r < 8) begin
                gen_noise();
                made++;
            end else if (r < 11 || (plan_heap.exh[0] && r < 60)) begin
                gen_build(n);
                made += n;
            end else begin
                gen_pop();
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------------
    task automatic wait_drained();
        @(negedge aclk);
        while (word_backlog.size() != 0 || s_valid || expected_merge_out.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_num_lists(input logic [kwmh_pkg::CFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        plan_heap.nlists = v;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (word_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                s_data  <= word_backlog.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------------
    task automatic cmp_field(input string name, input logic signed [63:0] expv,
                             input logic signed [63:0] gotv);
        if (gotv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, gotv);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        kwmh_pkg::in_word_t  w;
        kwmh_pkg::out_word_t r;
        kwmh_pkg::out_word_t e;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) dut_heap.nlists = cfg_wdata;
            if (s_valid && s_ready) begin
                w = s_data;
                if (heap_apply(dut_heap, w, r)) expected_merge_out.push_back(r);
            end
            if (m_valid && m_ready) begin
                if (expected_merge_out.size() == 0) begin
                    $error("unexpected result word: popped_list %0d next_list %0d",
                           m_data.popped_list, m_data.next_list);
                    err_count++;
                end else begin
                    e = expected_merge_out.pop_front();
                    cmp_field("popped_value", 64'(e.popped_value), 64'(m_data.popped_value));
                    cmp_field("popped_list",  64'(e.popped_list),  64'(m_data.popped_list));
                    cmp_field("popped_valid", 64'(e.popped_valid), 64'(m_data.popped_valid));
                    cmp_field("next_list",    64'(e.next_list),    64'(m_data.next_list));
                    cmp_field("next_valid",   64'(e.next_valid),   64'(m_data.next_valid));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_kway_merge_min_heap_unit: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int cfg_plan[12];
        int p;
        cfg_plan = '{16, 1, 7, 31, 2, 0, 12, 16, 3, 9, 16, 5};
        plan_heap = '0;
        plan_heap.nlists = 1;
        dut_heap = plan_heap;
        plan_written = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single list at reset size: extremes, slots past the heap, exhaustion
        push_word(kwmh_pkg::CMD_LOAD, 0,  32'h80000000, 1'b0);
        push_word(kwmh_pkg::CMD_LOAD, 15, 32'h7fffffff, 1'b0);
        push_word(kwmh_pkg::CMD_LOAD, 7,  32'd12345,    1'b1);
        push_word(kwmh_pkg::CMD_POP,  0,  32'h7fffffff, 1'b0);
        push_word(kwmh_pkg::CMD_POP,  15, 32'd0,        1'b1);
        push_word(kwmh_pkg::CMD_POP,  3,  32'hdeadbeef, 1'b0);
        push_word(kwmh_pkg::CMD_LOAD, 0,  32'd0,        1'b1);

        // four lists with tied heads, run until all are exhausted
        set_num_lists(4);
        push_word(kwmh_pkg::CMD_LOAD, 2, 32'd5,        1'b0);
        push_word(kwmh_pkg::CMD_LOAD, 0, 32'd5,        1'b0);
        push_word(kwmh_pkg::CMD_LOAD, 1, 32'hffffffff, 1'b0);
        push_word(kwmh_pkg::CMD_LOAD, 3, 32'd5,        1'b0);
        push_word(kwmh_pkg::CMD_POP,  0, 32'd5,        1'b0);
        push_word(kwmh_pkg::CMD_POP,  0, 32'h7fffffff, 1'b0);
        for (p = 0; p < 6; p++) push_word(kwmh_pkg::CMD_POP, 0, 32'd0, 1'b1);

        for (p = 0; p < 12; p++) begin
            set_num_lists(kwmh_pkg::CFG_W'(cfg_plan[p]));
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            if (p == 4) hold_req = 1'b1;
            gen_phase(58);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_kway_merge_min_heap_unit: clean");
        end else begin
            $display("tb_kway_merge_min_heap_unit: errors");
        end
        $finish;
    end

endmodule
